>>> hdl/pn_pkg.sv
// shared types and constants for the peak normalizer
`timescale 1ns / 1ps
package pn_pkg;

   // sample store geometry
   localparam int MAX_SAMPLES = 4096;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

   // field widths
   localparam int SAMPLE_W    = 24;
   localparam int TARGET_W    = 23;
   localparam int GAIN_W      = 40;
   localparam int GAIN_HALF   = GAIN_W / 2;
   localparam int FRAC_W      = 16;
   localparam int DIVIDEND_W  = TARGET_W + FRAC_W;
   localparam int PROD_W      = SAMPLE_W + GAIN_HALF;
   localparam int SUM_W       = SAMPLE_W + GAIN_W;
   localparam int STEP_W      = $clog2(DIVIDEND_W);

   localparam logic [GAIN_W-1:0]   UNITY_GAIN    = GAIN_W'(65536);
   localparam logic [TARGET_W-1:0] TARGET_RESET  = {TARGET_W{1'b1}};

   // opcodes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_GAIN   = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_FULL   = 2'd2;
   localparam logic [1:0] KIND_EMPTY  = 2'd3;

   // register map
   localparam logic [1:0] CSR_TARGET_ADDR = 2'd0;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_MUL_LO,
      S_MUL_HI,
      S_SCALE
   } state_type;

endpackage

>>> hdl/pn_ram.sv
// generic single-clock ram with registered read
`timescale 1ns / 1ps
module pn_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/peak_normalizer.sv
// peak normalizer: sample store, peak tracking, serial gain divide, scaled readout
// load: one sample per cycle, no result; store full error strobes the cycle after start
// finish: unity gain strobes the cycle after start, else 39 divider steps while busy,
// the gain is then registered; read: store read, two passes of a shared 24x20 multiplier,
// saturate, busy until the sample is out; nothing-to-read error strobes the cycle after start
// reset clears count, read index, peak, phase and sets unity gain; results cannot be stalled
`timescale 1ns / 1ps
module peak_normalizer
   import pn_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // command channel
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_opcode,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   // result channel
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_kind,
   output logic [GAIN_W-1:0]          rsp_gain,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic                       rsp_last,
   // configuration port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [1:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   state_type state_ff, state_in;

   logic [TARGET_W-1:0]   target_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [SAMPLE_W-1:0]   peak_ff, peak_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic                  reading_ff, reading_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic [GAIN_W-1:0]     rsp_gain_ff, rsp_gain_in;
   logic [SAMPLE_W-1:0]   rsp_sample_ff, rsp_sample_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  last_ff, last_in;

   // divider registers
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [SAMPLE_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   // multiplier registers
   logic [SAMPLE_W-1:0]   mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic [PROD_W-1:0]     pp_ff, pp_in;
   logic [PROD_W-1:0]     pp_lo_ff, pp_lo_in;

   logic                  accept;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [SAMPLE_W-1:0]   ram_rd_data;

   logic [CNT_W-1:0]      eff_count;
   logic [SAMPLE_W-1:0]   eff_peak;
   logic [SAMPLE_W-1:0]   in_mag;
   logic [SAMPLE_W-1:0]   rd_mag;

   logic [SAMPLE_W:0]     rem_shift;
   logic [SAMPLE_W+1:0]   rem_diff;
   logic                  rem_ge;

   logic [SAMPLE_W-1:0]   mul_a;
   logic [GAIN_HALF-1:0]  mul_b;
   logic [PROD_W-1:0]     mul_p;

   logic [SUM_W-1:0]      scale_sum;
   logic [SUM_W-FRAC_W-1:0] scale_q;
   logic [SUM_W-FRAC_W:0] scale_qr;
   logic                  scale_frac;
   logic [SAMPLE_W-1:0]   scale_out;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // configuration port
   assign pready = 1'b1;
   assign prdata = 32'(target_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
      end else if (psel && penable && pwrite && pready && paddr == CSR_TARGET_ADDR) begin
         target_ff <= pwdata[TARGET_W-1:0];
      end
   end

   // a load after finish starts a new region
   assign eff_count = reading_ff ? '0 : count_ff;
   assign eff_peak  = reading_ff ? '0 : peak_ff;
   assign in_mag    = req_sample_in[SAMPLE_W-1] ? (~req_sample_in + 1'b1) : req_sample_in;
   assign rd_mag    = ram_rd_data[SAMPLE_W-1] ? (~ram_rd_data + 1'b1) : ram_rd_data;

   assign ram_wr_en = accept && req_opcode == OP_LOAD && eff_count < CNT_W'(MAX_SAMPLES);
   assign ram_rd_en = accept && req_opcode == OP_READ && reading_ff && rd_idx_ff < count_ff;

   pn_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_SAMPLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (eff_count[ADDR_W-1:0]),
      .wr_data (req_sample_in),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // restoring divider step
   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, peak_ff};
   assign rem_ge    = !rem_diff[SAMPLE_W+1];

   // shared multiplier: low gain half, then high gain half
   assign mul_a = (state_ff == S_MUL_LO) ? rd_mag : mag_ff;
   assign mul_b = (state_ff == S_MUL_LO) ? gain_ff[GAIN_HALF-1:0]
                                         : gain_ff[GAIN_W-1:GAIN_HALF];
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // combine partial products, floor toward minus infinity, saturate
   assign scale_sum  = SUM_W'(pp_lo_ff) + {pp_ff, {GAIN_HALF{1'b0}}};
   assign scale_q    = scale_sum[SUM_W-1:FRAC_W];
   assign scale_frac = |scale_sum[FRAC_W-1:0];
   assign scale_qr   = {1'b0, scale_q} + (SUM_W-FRAC_W+1)'(scale_frac);

   always_comb begin
      if (neg_ff) begin
         if (|scale_qr[SUM_W-FRAC_W:SAMPLE_W-1]) begin
            scale_out = {1'b1, {(SAMPLE_W-1){1'b0}}};
         end else begin
            scale_out = ~scale_qr[SAMPLE_W-1:0] + 1'b1;
         end
      end else begin
         if (|scale_q[SUM_W-FRAC_W-1:SAMPLE_W-1]) begin
            scale_out = {1'b0, {(SAMPLE_W-1){1'b1}}};
         end else begin
            scale_out = scale_q[SAMPLE_W-1:0];
         end
      end
   end

   // sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      peak_in       = peak_ff;
      gain_in       = gain_ff;
      reading_in    = reading_ff;
      last_in       = last_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      pp_in         = pp_ff;
      pp_lo_in      = pp_lo_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_gain_in   = rsp_gain_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_LOAD: begin
                     if (reading_ff) begin
                        reading_in = 1'b0;
                        rd_idx_in  = '0;
                        gain_in    = UNITY_GAIN;
                        count_in   = '0;
                        peak_in    = '0;
                     end
                     if (eff_count < CNT_W'(MAX_SAMPLES)) begin
                        count_in = eff_count + 1'b1;
                        peak_in  = (in_mag > eff_peak) ? in_mag : eff_peak;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = KIND_FULL;
                        rsp_gain_in   = '0;
                        rsp_sample_in = '0;
                        rsp_last_in   = 1'b0;
                     end
                  end
                  OP_FINISH: begin
                     reading_in = 1'b1;
                     rd_idx_in  = '0;
                     if (count_ff == '0 || peak_ff == '0) begin
                        gain_in       = UNITY_GAIN;
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = KIND_GAIN;
                        rsp_gain_in   = UNITY_GAIN;
                        rsp_sample_in = '0;
                        rsp_last_in   = 1'b0;
                     end else begin
                        quo_in   = {target_ff, {FRAC_W{1'b0}}};
                        rem_in   = '0;
                        step_in  = STEP_W'(DIVIDEND_W - 1);
                        state_in = S_DIV;
                     end
                  end
                  OP_READ: begin
                     if (ram_rd_en) begin
                        last_in   = (rd_idx_ff + 1'b1 == count_ff);
                        rd_idx_in = rd_idx_ff + 1'b1;
                        state_in  = S_MUL_LO;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_kind_in   = KIND_EMPTY;
                        rsp_gain_in   = '0;
                        rsp_sample_in = '0;
                        rsp_last_in   = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            rem_in  = rem_ge ? rem_diff[SAMPLE_W-1:0] : rem_shift[SAMPLE_W-1:0];
            quo_in  = {quo_ff[DIVIDEND_W-2:0], rem_ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               gain_in       = GAIN_W'(quo_in);
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_GAIN;
               rsp_gain_in   = GAIN_W'(quo_in);
               rsp_sample_in = '0;
               rsp_last_in   = 1'b0;
               state_in      = S_IDLE;
            end
         end
         S_MUL_LO: begin
            mag_in   = rd_mag;
            neg_in   = ram_rd_data[SAMPLE_W-1];
            pp_in    = mul_p;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            pp_lo_in = pp_ff;
            pp_in    = mul_p;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_SAMPLE;
            rsp_gain_in   = '0;
            rsp_sample_in = scale_out;
            rsp_last_in   = last_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         peak_ff      <= '0;
         gain_ff      <= UNITY_GAIN;
         reading_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         peak_ff      <= peak_in;
         gain_ff      <= gain_in;
         reading_ff   <= reading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and result payload registers
   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      pp_ff         <= pp_in;
      pp_lo_ff      <= pp_lo_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_gain_ff   <= rsp_gain_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_gain       = rsp_gain_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_last       = rsp_last_ff;

   // no transfer while the divider runs
   a_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> !rsp_valid)
      else $error("result strobe during divide");

   // last flag only on scaled samples
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_kind == KIND_SAMPLE))
      else $error("last flag on non-sample result");

   // a started read ends in a sample transfer
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCALE) |=> (rsp_valid && rsp_kind == KIND_SAMPLE))
      else $error("scaled sample not delivered");

   // read position never passes the fill count
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (rd_idx_ff <= count_ff) && (count_ff <= CNT_W'(MAX_SAMPLES)))
      else $error("read index or count out of range");

endmodule
